// ===== sv/pswd_pkg.sv =====
// shared types and constants for the progress stall watchdog
package pswd_pkg;

  localparam int TICK_BITS    = 64;
  localparam int PENDING_BITS = 32;
  localparam int MEMORY_BITS  = 40;
  localparam int THRESH_BITS  = 16;
  localparam int PERCENT_BITS = 7;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 40;
  localparam int PRODUCT_BITS   = MEMORY_BITS + PERCENT_BITS;

  localparam logic [PERCENT_BITS-1:0] PERCENT_SCALE = 7'd100;

  // register indexes of the configuration port
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_WARN_SAMPLES      = 3'd0,
    REG_CRITICAL_SAMPLES  = 3'd1,
    REG_DRAIN_MIN_PENDING = 3'd2,
    REG_MEMORY_PERCENT    = 3'd3,
    REG_MEMORY_RISE       = 3'd4
  } cfg_reg_t;

  localparam logic [THRESH_BITS-1:0]  WARN_RESET     = 16'd5;
  localparam logic [THRESH_BITS-1:0]  CRITICAL_RESET = 16'd15;
  localparam logic [PENDING_BITS-1:0] DRAIN_RESET    = 32'd4;
  localparam logic [PERCENT_BITS-1:0] PERCENT_RESET  = 7'd90;
  localparam logic [MEMORY_BITS-1:0]  RISE_RESET     = 40'd16777216;

  typedef struct packed {
    logic [THRESH_BITS-1:0]  warn_samples;
    logic [THRESH_BITS-1:0]  critical_samples;
    logic [PENDING_BITS-1:0] drain_min_pending;
    logic [PERCENT_BITS-1:0] memory_percent_limit;
    logic [MEMORY_BITS-1:0]  memory_rise_bytes;
  } cfg_t;

  typedef struct packed {
    logic [TICK_BITS-1:0]    tick_value;
    logic [TICK_BITS-1:0]    kick_value;
    logic [PENDING_BITS-1:0] queued_submits;
    logic [MEMORY_BITS-1:0]  memory_used;
    logic [MEMORY_BITS-1:0]  memory_budget;
  } sample_t;

  typedef struct packed {
    logic                   progress_seen;
    logic                   tick_same;
    logic [THRESH_BITS-1:0] stalled_samples;
    logic                   warn_pulse;
    logic                   critical_pulse;
  } stall_status_t;

  typedef struct packed {
    logic drain_stall;
    logic memory_climbing;
  } flag_status_t;

endpackage

// ===== sv/pswd_if.sv =====
// sample and result channel interfaces
interface pswd_sample_if;
  logic        valid;
  logic        ready;
  logic [63:0] tick_value;
  logic [63:0] kick_value;
  logic [31:0] queued_submits;
  logic [39:0] memory_used;
  logic [39:0] memory_budget;

  modport source (output valid, output tick_value, output kick_value,
                  output queued_submits, output memory_used, output memory_budget,
                  input ready);
  modport sink (input valid, input tick_value, input kick_value,
                input queued_submits, input memory_used, input memory_budget,
                output ready);
endinterface

interface pswd_result_if;
  logic        valid;
  logic        ready;
  logic        progress_seen;
  logic [15:0] stalled_samples;
  logic        warn_pulse;
  logic        critical_pulse;
  logic        drain_stall;
  logic        memory_climbing;

  modport source (output valid, output progress_seen, output stalled_samples,
                  output warn_pulse, output critical_pulse, output drain_stall,
                  output memory_climbing, input ready);
  modport sink (input valid, input progress_seen, input stalled_samples,
                input warn_pulse, input critical_pulse, input drain_stall,
                input memory_climbing, output ready);
endinterface

// ===== sv/progress_stall_watchdog.sv =====
// progress stall watchdog: per-sample stall counting and health flags
// path: an accepted sample is registered in the input register, then its result in the result register
// throughput: one sample per cycle, the result register holds while the sink stalls
//   and one more sample waits in the input register
// reset: synchronous, clears both pipeline stages, the history and the stall count,
//   and loads the configuration registers with their defaults
module progress_stall_watchdog #(
  parameter int STALL_COUNT_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  pswd_sample_if.sink                         sample,
  pswd_result_if.source                       result,
  input  logic                                cfg_write,
  input  logic [pswd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [pswd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  pswd_pkg::cfg_t          cfg;
  pswd_pkg::sample_t       in_q;
  logic                    in_valid;
  pswd_pkg::stall_status_t stall;
  pswd_pkg::flag_status_t  flags;
  logic                    res_valid;
  logic                    advance;

  // configuration, to be written only while no transaction is in flight; the block itself does not enforce this
  pswd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // the sample in the input register moves to the result register whenever
  // that register is empty or being drained this cycle
  assign advance      = in_valid && (!res_valid || result.ready);
  assign sample.ready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sample.ready) begin
      in_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      in_q.tick_value     <= sample.tick_value;
      in_q.kick_value     <= sample.kick_value;
      in_q.queued_submits <= sample.queued_submits;
      in_q.memory_used    <= sample.memory_used;
      in_q.memory_budget  <= sample.memory_budget;
    end
  end

  // history and stall counter, updated as each sample moves on
  pswd_stall #(
    .STALL_COUNT_BITS (STALL_COUNT_BITS)
  ) u_stall (
    .clk              (clk),
    .rst              (rst),
    .step             (advance),
    .tick_value       (in_q.tick_value),
    .kick_value       (in_q.kick_value),
    .warn_samples     (cfg.warn_samples),
    .critical_samples (cfg.critical_samples),
    .status           (stall)
  );

  // drain and memory checks, sharing the tick comparison
  pswd_flags u_flags (
    .clk            (clk),
    .rst            (rst),
    .step           (advance),
    .tick_same      (stall.tick_same),
    .queued_submits (in_q.queued_submits),
    .memory_used    (in_q.memory_used),
    .memory_budget  (in_q.memory_budget),
    .cfg            (cfg),
    .flags          (flags)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.progress_seen   <= stall.progress_seen;
      result.stalled_samples <= stall.stalled_samples;
      result.warn_pulse      <= stall.warn_pulse;
      result.critical_pulse  <= stall.critical_pulse;
      result.drain_stall     <= flags.drain_stall;
      result.memory_climbing <= flags.memory_climbing;
    end
  end

  assign result.valid = res_valid;

endmodule

// ===== sv/pswd_cfg.sv =====
// configuration register file
module pswd_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [pswd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [pswd_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output pswd_pkg::cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.warn_samples         <= pswd_pkg::WARN_RESET;
      cfg.critical_samples     <= pswd_pkg::CRITICAL_RESET;
      cfg.drain_min_pending    <= pswd_pkg::DRAIN_RESET;
      cfg.memory_percent_limit <= pswd_pkg::PERCENT_RESET;
      cfg.memory_rise_bytes    <= pswd_pkg::RISE_RESET;
    end else if (cfg_write) begin
      case (pswd_pkg::cfg_reg_t'(cfg_index))
        pswd_pkg::REG_WARN_SAMPLES:
          cfg.warn_samples <= cfg_data[pswd_pkg::THRESH_BITS-1:0];
        pswd_pkg::REG_CRITICAL_SAMPLES:
          cfg.critical_samples <= cfg_data[pswd_pkg::THRESH_BITS-1:0];
        pswd_pkg::REG_DRAIN_MIN_PENDING:
          cfg.drain_min_pending <= cfg_data[pswd_pkg::PENDING_BITS-1:0];
        pswd_pkg::REG_MEMORY_PERCENT:
          cfg.memory_percent_limit <= cfg_data[pswd_pkg::PERCENT_BITS-1:0];
        pswd_pkg::REG_MEMORY_RISE:
          cfg.memory_rise_bytes <= cfg_data[pswd_pkg::MEMORY_BITS-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

endmodule

// ===== sv/pswd_stall.sv =====
// progress detection and saturating stall counter with one-shot pulses
module pswd_stall #(
  parameter int STALL_COUNT_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                step,
  input  logic [pswd_pkg::TICK_BITS-1:0]      tick_value,
  input  logic [pswd_pkg::TICK_BITS-1:0]      kick_value,
  input  logic [pswd_pkg::THRESH_BITS-1:0]    warn_samples,
  input  logic [pswd_pkg::THRESH_BITS-1:0]    critical_samples,
  output pswd_pkg::stall_status_t             status
);

  localparam int CMP_BITS = (STALL_COUNT_BITS > pswd_pkg::THRESH_BITS) ?
                            STALL_COUNT_BITS : pswd_pkg::THRESH_BITS;
  localparam logic [CMP_BITS-1:0] SHOW_MAX = CMP_BITS'({pswd_pkg::THRESH_BITS{1'b1}});

  logic [pswd_pkg::TICK_BITS-1:0] previous_tick;
  logic [pswd_pkg::TICK_BITS-1:0] previous_kick;
  logic [STALL_COUNT_BITS-1:0]    stall_count;
  logic                           warn_done;
  logic                           critical_done;

  logic [STALL_COUNT_BITS-1:0] stall_count_next;
  logic                        warn_done_next;
  logic                        critical_done_next;
  logic [CMP_BITS-1:0]         count_wide;
  logic                        progress;
  logic                        warn;
  logic                        crit;

  always_comb begin
    progress = (tick_value != previous_tick) || (kick_value != previous_kick);
    if (progress) begin
      stall_count_next = '0;
    end else if (stall_count != {STALL_COUNT_BITS{1'b1}}) begin
      stall_count_next = stall_count + 1'b1;
    end else begin
      stall_count_next = stall_count;
    end
    count_wide = CMP_BITS'(stall_count_next);
    warn = !progress && !warn_done && (count_wide >= CMP_BITS'(warn_samples));
    crit = !progress && !critical_done &&
           (count_wide >= CMP_BITS'(critical_samples));
    warn_done_next     = !progress && (warn_done || warn);
    critical_done_next = !progress && (critical_done || crit);

    status.progress_seen  = progress;
    status.tick_same      = (tick_value == previous_tick);
    status.warn_pulse     = warn;
    status.critical_pulse = crit;
    status.stalled_samples = (count_wide > SHOW_MAX) ?
                             {pswd_pkg::THRESH_BITS{1'b1}} :
                             count_wide[pswd_pkg::THRESH_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_tick <= '0;
      previous_kick <= '0;
      stall_count   <= '0;
      warn_done     <= 1'b0;
      critical_done <= 1'b0;
    end else if (step) begin
      previous_tick <= tick_value;
      previous_kick <= kick_value;
      stall_count   <= stall_count_next;
      warn_done     <= warn_done_next;
      critical_done <= critical_done_next;
    end
  end

endmodule

// ===== sv/pswd_flags.sv =====
// drain stall and memory climbing flags
module pswd_flags (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                step,
  input  logic                                tick_same,
  input  logic [pswd_pkg::PENDING_BITS-1:0]   queued_submits,
  input  logic [pswd_pkg::MEMORY_BITS-1:0]    memory_used,
  input  logic [pswd_pkg::MEMORY_BITS-1:0]    memory_budget,
  input  pswd_pkg::cfg_t                      cfg,
  output pswd_pkg::flag_status_t              flags
);

  logic [pswd_pkg::PENDING_BITS-1:0] previous_pending;
  logic [pswd_pkg::MEMORY_BITS-1:0]  previous_memory;

  logic [pswd_pkg::PRODUCT_BITS-1:0] used_scaled;
  logic [pswd_pkg::PRODUCT_BITS-1:0] budget_scaled;
  logic [pswd_pkg::MEMORY_BITS:0]    memory_floor;

  always_comb begin
    used_scaled   = pswd_pkg::PRODUCT_BITS'(memory_used) *
                    pswd_pkg::PRODUCT_BITS'(pswd_pkg::PERCENT_SCALE);
    budget_scaled = pswd_pkg::PRODUCT_BITS'(memory_budget) *
                    pswd_pkg::PRODUCT_BITS'(cfg.memory_percent_limit);
    memory_floor  = {1'b0, previous_memory} + {1'b0, cfg.memory_rise_bytes};

    flags.drain_stall = tick_same && (queued_submits > previous_pending) &&
                        (queued_submits > cfg.drain_min_pending);
    flags.memory_climbing = (memory_budget != '0) && (used_scaled > budget_scaled) &&
                            ({1'b0, memory_used} > memory_floor);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_pending <= '0;
      previous_memory  <= '0;
    end else if (step) begin
      previous_pending <= queued_submits;
      previous_memory  <= memory_used;
    end
  end

endmodule

// ===== sv/pswd_checker.sv =====
// port-level checks for the progress stall watchdog, bound to the top level
module pswd_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic        progress_seen,
  input logic [15:0] stalled_samples,
  input logic        warn_pulse,
  input logic        critical_pulse,
  input logic        drain_stall,
  input logic        memory_climbing
);

  // a progress transaction always shows a cleared count and no pulse
  assert property (@(posedge clk) disable iff (rst)
    res_valid && progress_seen |-> stalled_samples == 16'd0 && !warn_pulse && !critical_pulse)
    else $error("progress transaction with stall count or pulse");

  // a pulse only comes from a stalled sample with a nonzero count
  assert property (@(posedge clk) disable iff (rst)
    res_valid && (warn_pulse || critical_pulse) |-> !progress_seen && stalled_samples != 16'd0)
    else $error("pulse without a stall");

  // nothing leaves the block in the cycle after reset
  assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid straight after reset");

  // a stalled result is held unchanged
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(stalled_samples) &&
      $stable(progress_seen) && $stable(warn_pulse) && $stable(critical_pulse) &&
      $stable(drain_stall) && $stable(memory_climbing))
    else $error("stalled result changed");

endmodule

bind progress_stall_watchdog pswd_checker u_pswd_checker (
  .clk             (clk),
  .rst             (rst),
  .res_valid       (result.valid),
  .res_ready       (result.ready),
  .progress_seen   (result.progress_seen),
  .stalled_samples (result.stalled_samples),
  .warn_pulse      (result.warn_pulse),
  .critical_pulse  (result.critical_pulse),
  .drain_stall     (result.drain_stall),
  .memory_climbing (result.memory_climbing)
);
